>>> hdl/lis_pkg.sv
`default_nettype none
package lis_pkg;

	localparam int MAX_ITEMS_DEF  = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF = 32;

	// Control bits that travel with the beat along the cell row.
	typedef struct packed {
		logic valid;
		logic sat;
	} lis_ctl_t;

endpackage
`default_nettype wire

>>> hdl/lis_cell.sv
`default_nettype none
module lis_cell #(
	parameter int INDEX      = 0,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 32,
	parameter int LEN_W      = 11,
	parameter int IDX_W      = 11
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lis_pkg::lis_ctl_t     prev_ctl,
	input  wire [VALUE_BITS-1:0]  prev_key,
	input  wire [LEN_W-1:0]       prev_len,
	input  wire [COUNT_BITS-1:0]  prev_cnt,
	input  wire [IDX_W-1:0]       prev_n,
	output lis_pkg::lis_ctl_t     next_ctl,
	output logic [VALUE_BITS-1:0] next_key,
	output logic [LEN_W-1:0]      next_len,
	output logic [COUNT_BITS-1:0] next_cnt,
	output logic [IDX_W-1:0]      next_n
);
	import lis_pkg::*;

	// Stored entry of this position.
	logic [VALUE_BITS-1:0] val_q;
	logic [LEN_W-1:0]      len_q;
	logic [COUNT_BITS-1:0] cnt_q;

	logic                  occupied;
	logic                  smaller;
	logic [LEN_W-1:0]      cand;
	logic [COUNT_BITS:0]   sum;
	logic [LEN_W-1:0]      upd_len;
	logic [COUNT_BITS-1:0] upd_cnt;
	logic                  upd_sat;

	lis_ctl_t              ctl_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [LEN_W-1:0]      tlen_q;
	logic [COUNT_BITS-1:0] tcnt_q;
	logic [IDX_W-1:0]      n_q;

	assign occupied = prev_n > IDX_W'(INDEX);
	assign smaller  = val_q < prev_key;
	assign cand     = len_q + LEN_W'(1);
	assign sum      = {1'b0, prev_cnt} + {1'b0, cnt_q};

	always_comb begin
		upd_len = prev_len;
		upd_cnt = prev_cnt;
		upd_sat = prev_ctl.sat;
		if (prev_ctl.valid && occupied && smaller) begin
			if (cand > prev_len) begin
				upd_len = cand;
				upd_cnt = cnt_q;
			end else if (cand == prev_len) begin
				if (sum[COUNT_BITS]) begin
					upd_cnt = '1;
					upd_sat = 1'b1;
				end else begin
					upd_cnt = sum[COUNT_BITS-1:0];
				end
			end
		end
	end

	// The first free position takes the entry as it arrives, with all
	// earlier entries already folded in.
	always_ff @(posedge clk) begin
		if (prev_ctl.valid && (prev_n == IDX_W'(INDEX))) begin
			val_q <= prev_key;
			len_q <= prev_len;
			cnt_q <= prev_cnt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q.valid <= prev_ctl.valid;
			ctl_q.sat   <= upd_sat;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= prev_key;
		tlen_q <= upd_len;
		tcnt_q <= upd_cnt;
		n_q    <= prev_n;
	end

	assign next_ctl = ctl_q;
	assign next_key = key_q;
	assign next_len = tlen_q;
	assign next_cnt = tcnt_q;
	assign next_n   = n_q;

endmodule
`default_nettype wire

>>> hdl/lis_chain.sv
`default_nettype none
module lis_chain #(
	parameter int MAX_ITEMS  = 1024,
	parameter int VALUE_BITS = 32,
	parameter int COUNT_BITS = 32,
	parameter int LEN_W      = 11,
	parameter int IDX_W      = 11
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  lis_pkg::lis_ctl_t     head_ctl,
	input  wire [VALUE_BITS-1:0]  head_key,
	input  wire [LEN_W-1:0]       head_len,
	input  wire [COUNT_BITS-1:0]  head_cnt,
	input  wire [IDX_W-1:0]       head_n,
	output lis_pkg::lis_ctl_t     tail_ctl,
	output logic [LEN_W-1:0]      tail_len,
	output logic [COUNT_BITS-1:0] tail_cnt
);
	import lis_pkg::*;

	lis_ctl_t              ctl_w [0:MAX_ITEMS];
	logic [VALUE_BITS-1:0] key_w [0:MAX_ITEMS];
	logic [LEN_W-1:0]      len_w [0:MAX_ITEMS];
	logic [COUNT_BITS-1:0] cnt_w [0:MAX_ITEMS];
	logic [IDX_W-1:0]      n_w   [0:MAX_ITEMS];

	assign ctl_w[0] = head_ctl;
	assign key_w[0] = head_key;
	assign len_w[0] = head_len;
	assign cnt_w[0] = head_cnt;
	assign n_w[0]   = head_n;

	for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
		lis_cell #(
			.INDEX      (i),
			.VALUE_BITS (VALUE_BITS),
			.COUNT_BITS (COUNT_BITS),
			.LEN_W      (LEN_W),
			.IDX_W      (IDX_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.prev_ctl (ctl_w[i]),
			.prev_key (key_w[i]),
			.prev_len (len_w[i]),
			.prev_cnt (cnt_w[i]),
			.prev_n   (n_w[i]),
			.next_ctl (ctl_w[i+1]),
			.next_key (key_w[i+1]),
			.next_len (len_w[i+1]),
			.next_cnt (cnt_w[i+1]),
			.next_n   (n_w[i+1])
		);
	end

	assign tail_ctl = ctl_w[MAX_ITEMS];
	assign tail_len = len_w[MAX_ITEMS];
	assign tail_cnt = cnt_w[MAX_ITEMS];

endmodule
`default_nettype wire

>>> hdl/count_longest_increasing_subseq_unit.sv
`default_nettype none
// Counts the longest strictly increasing subsequences of a stream of signed
// values, one value per input beat; start_req begins a new sequence. Each
// accepted value is sent down a row of MAX_ITEMS cells, one cell per cycle;
// every occupied cell holds one earlier value with its length and count and
// folds them into the passing beat, and the first free cell stores the new
// entry. A new value waits until the last has left the cell row and its
// result is in the output register, whatever the sequence length. A value
// offered to a full store is not sent down the row and is rejected. The
// result sits in an output register, so a new item is taken while it waits.
// Counts saturate at all ones and set count_saturated until the next start.
module count_longest_increasing_subseq_unit #(
	parameter int MAX_ITEMS  = lis_pkg::MAX_ITEMS_DEF,
	parameter int VALUE_BITS = lis_pkg::VALUE_BITS_DEF,
	parameter int COUNT_BITS = lis_pkg::COUNT_BITS_DEF,
	parameter int LEN_W      = $clog2(MAX_ITEMS + 1)
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire [VALUE_BITS-1:0]  value,
	input  wire                   start_req,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [LEN_W-1:0]      best_length,
	output logic [COUNT_BITS-1:0] best_count,
	output logic                  count_saturated,
	output logic                  rejected
);
	import lis_pkg::*;

	localparam int IDX_W = $clog2(MAX_ITEMS + 1);

	logic [IDX_W-1:0]      total_q;
	logic [LEN_W-1:0]      best_len_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic                  sat_q;
	logic                  busy_q;
	logic                  pend_q;
	logic                  rej_q;
	logic                  out_valid_q;

	logic                  accept;
	logic [IDX_W-1:0]      n_eff;
	logic                  full;
	logic                  load_out;
	lis_ctl_t              head_ctl;
	logic [VALUE_BITS-1:0] head_key;
	lis_ctl_t              tail_ctl;
	logic [LEN_W-1:0]      tail_len;
	logic [COUNT_BITS-1:0] tail_cnt;
	logic [COUNT_BITS:0]   best_sum;

	assign in_ready = !busy_q && !pend_q;
	assign accept   = in_valid && in_ready;
	assign n_eff    = start_req ? '0 : total_q;
	assign full     = n_eff == IDX_W'(MAX_ITEMS);
	assign load_out = pend_q && (!out_valid_q || out_ready);

	// Flipping the sign bit makes unsigned order match signed order.
	assign head_key       = {~value[VALUE_BITS-1], value[VALUE_BITS-2:0]};
	assign head_ctl.valid = accept && !full;
	assign head_ctl.sat   = start_req ? 1'b0 : sat_q;

	lis_chain #(
		.MAX_ITEMS  (MAX_ITEMS),
		.VALUE_BITS (VALUE_BITS),
		.COUNT_BITS (COUNT_BITS),
		.LEN_W      (LEN_W),
		.IDX_W      (IDX_W)
	) u_chain (
		.clk      (clk),
		.arst_n   (arst_n),
		.head_ctl (head_ctl),
		.head_key (head_key),
		.head_len (LEN_W'(1)),
		.head_cnt (COUNT_BITS'(1)),
		.head_n   (n_eff),
		.tail_ctl (tail_ctl),
		.tail_len (tail_len),
		.tail_cnt (tail_cnt)
	);

	assign best_sum = {1'b0, best_cnt_q} + {1'b0, tail_cnt};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			best_len_q  <= '0;
			best_cnt_q  <= '0;
			sat_q       <= 1'b0;
			busy_q      <= 1'b0;
			pend_q      <= 1'b0;
			rej_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				if (start_req) begin
					total_q    <= '0;
					best_len_q <= '0;
					best_cnt_q <= '0;
					sat_q      <= 1'b0;
				end
				if (full) begin
					pend_q <= 1'b1;
					rej_q  <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end
			if (tail_ctl.valid) begin
				busy_q  <= 1'b0;
				pend_q  <= 1'b1;
				rej_q   <= 1'b0;
				total_q <= total_q + IDX_W'(1);
				sat_q   <= tail_ctl.sat;
				if (tail_len > best_len_q) begin
					best_len_q <= tail_len;
					best_cnt_q <= tail_cnt;
				end else if (tail_len == best_len_q) begin
					if (best_sum[COUNT_BITS]) begin
						best_cnt_q <= '1;
						sat_q      <= 1'b1;
					end else begin
						best_cnt_q <= best_sum[COUNT_BITS-1:0];
					end
				end
			end
			if (load_out) begin
				pend_q      <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			best_length     <= best_len_q;
			best_count      <= best_cnt_q;
			count_saturated <= sat_q;
			rejected        <= rej_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

>>> hdl/lis_checker.sv
`default_nettype none
module lis_checker #(
	parameter int MAX_ITEMS  = lis_pkg::MAX_ITEMS_DEF,
	parameter int COUNT_BITS = lis_pkg::COUNT_BITS_DEF,
	parameter int LEN_W      = $clog2(MAX_ITEMS + 1)
) (
	input wire                  clk,
	input wire                  arst_n,
	input wire                  in_valid,
	input wire                  in_ready,
	input wire                  out_valid,
	input wire                  out_ready,
	input wire [LEN_W-1:0]      best_length,
	input wire [COUNT_BITS-1:0] best_count,
	input wire                  count_saturated,
	input wire                  rejected
);
	import lis_pkg::*;

	// A stalled result must hold.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(best_length)
			&& $stable(best_count) && $stable(count_saturated) && $stable(rejected))
		else $error("result changed while stalled");

	// Only one item is in work at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while an item is in work");

	// Every reported result follows at least one stored value.
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length != '0 && best_count != '0)
		else $error("empty result reported");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> best_length <= LEN_W'(MAX_ITEMS))
		else $error("length beyond capacity");

endmodule

bind count_longest_increasing_subseq_unit lis_checker #(
	.MAX_ITEMS  (MAX_ITEMS),
	.COUNT_BITS (COUNT_BITS),
	.LEN_W      (LEN_W)
) u_lis_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.best_length     (best_length),
	.best_count      (best_count),
	.count_saturated (count_saturated),
	.rejected        (rejected)
);
`default_nettype wire
